### rtl/core/twec_pkg.sv
package twec_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 48;
    localparam int SUM_W       = TIME_W + 1;
    localparam int COUNT_W     = 13;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_TRIGGER = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_OOB    = 2'd1,
        STATUS_HALTED = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_OFFSET = 1'd0,
        CFG_TAIL_OFFSET = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0] head_offset;
        logic [TIME_W-1:0] tail_offset;
    } window_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] event_count;
        status_t            status;
    } result_t;

endpackage

### rtl/core/twec_ctrl.sv
module twec_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  twec_pkg::window_cfg_t               cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [twec_pkg::KIND_W-1:0]         in_kind,
    input  logic [twec_pkg::TIME_W-1:0]         in_time,
    output logic                                res_valid,
    input  logic                                res_ready,
    output twec_pkg::result_t                   res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TAIL,
        ST_RESULT
    } state_t;

    state_t                          state_reg,   state_next;
    logic [twec_pkg::CNT_W-1:0]      loaded_reg,  loaded_next;
    logic [twec_pkg::CNT_W-1:0]      ptr_reg,     ptr_next;
    logic                            halted_reg,  halted_next;
    logic [twec_pkg::CNT_W-1:0]      cur_reg,     cur_next;
    logic [twec_pkg::CNT_W-1:0]      hi_reg,      hi_next;
    logic [twec_pkg::SUM_W-1:0]      start_reg,   start_next;
    logic [twec_pkg::SUM_W-1:0]      end_reg,     end_next;
    twec_pkg::result_t               res_reg,     res_next;

    logic [twec_pkg::TIME_W-1:0]     mem [twec_pkg::STORE_DEPTH];
    logic [twec_pkg::TIME_W-1:0]     rdata_reg;
    logic                            wr_en;
    logic [twec_pkg::IDX_W-1:0]      wr_addr;
    logic [twec_pkg::IDX_W-1:0]      rd_addr;
    logic [twec_pkg::CNT_W-1:0]      from_idx;
    logic [twec_pkg::CNT_W-1:0]      cur_inc;
    logic [twec_pkg::CNT_W-1:0]      span;
    logic [twec_pkg::SUM_W-1:0]      rd_ext;
    logic                            in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    assign from_idx = (ptr_reg > loaded_reg) ? loaded_reg : ptr_reg;
    assign cur_inc  = cur_reg + twec_pkg::CNT_W'(1);
    assign span     = cur_reg - hi_reg;
    assign rd_ext   = {1'b0, rdata_reg};
    assign rd_addr  = (state_reg == ST_IDLE) ? from_idx[twec_pkg::IDX_W-1:0]
                                             : cur_inc[twec_pkg::IDX_W-1:0];
    assign wr_addr  = loaded_reg[twec_pkg::IDX_W-1:0];

    // event store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_time;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        ptr_next    = ptr_reg;
        halted_next = halted_reg;
        cur_next    = cur_reg;
        hi_next     = hi_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (twec_pkg::kind_t'(in_kind))
                        twec_pkg::KIND_LOAD:
                        begin
                            if (loaded_reg < twec_pkg::CNT_W'(twec_pkg::STORE_DEPTH))
                            begin
                                wr_en       = 1'b1;
                                loaded_next = loaded_reg + twec_pkg::CNT_W'(1);
                            end
                        end
                        twec_pkg::KIND_RESTART:
                        begin
                            loaded_next = '0;
                            ptr_next    = '0;
                            halted_next = 1'b0;
                        end
                        twec_pkg::KIND_TRIGGER:
                        begin
                            if (halted_reg)
                            begin
                                res_next.event_count = '0;
                                res_next.status      = twec_pkg::STATUS_HALTED;
                                state_next           = ST_RESULT;
                            end
                            else
                            begin
                                start_next = {1'b0, in_time} + {1'b0, cfg.head_offset};
                                end_next   = {1'b0, in_time} + {1'b0, cfg.tail_offset};
                                cur_next   = from_idx;
                                state_next = ST_HEAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_HEAD:
            begin
                priority if (cur_reg >= loaded_reg)
                begin
                    halted_next          = 1'b1;
                    res_next.event_count = '0;
                    res_next.status      = twec_pkg::STATUS_OOB;
                    state_next           = ST_RESULT;
                end
                else if (rd_ext >= start_reg)
                begin
                    hi_next = cur_reg;
                    if (rd_ext > end_reg)
                    begin
                        ptr_next             = cur_reg;
                        res_next.event_count = '0;
                        res_next.status      = twec_pkg::STATUS_OK;
                        state_next           = ST_RESULT;
                    end
                    else
                    begin
                        cur_next   = cur_inc;
                        state_next = ST_TAIL;
                    end
                end
                else
                begin
                    cur_next = cur_inc;
                end
            end
            ST_TAIL:
            begin
                if (cur_reg >= loaded_reg || rd_ext > end_reg)
                begin
                    ptr_next             = cur_reg;
                    res_next.event_count = twec_pkg::COUNT_W'(span);
                    res_next.status      = twec_pkg::STATUS_OK;
                    state_next           = ST_RESULT;
                end
                else
                begin
                    cur_next = cur_inc;
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            loaded_reg <= '0;
            ptr_reg    <= '0;
            halted_reg <= 1'b0;
            cur_reg    <= '0;
            hi_reg     <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            ptr_reg    <= ptr_next;
            halted_reg <= halted_next;
            cur_reg    <= cur_next;
            hi_reg     <= hi_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            res_reg    <= res_next;
        end
    end

    a_ptr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= loaded_reg)
        else $error("search pointer beyond loaded list");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= twec_pkg::CNT_W'(twec_pkg::STORE_DEPTH))
        else $error("loaded count beyond store depth");

    a_tail_after_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAIL |-> (hi_reg < cur_reg && cur_reg <= loaded_reg))
        else $error("tail scan index out of order");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_kind == twec_pkg::KIND_RESTART) |=>
            (loaded_reg == '0 && ptr_reg == '0 && !halted_reg))
        else $error("restart did not clear list state");

    a_oob_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HEAD && cur_reg >= loaded_reg) |=>
            (halted_reg && state_reg == ST_RESULT))
        else $error("out-of-bounds trigger did not halt");

endmodule

### rtl/core/trigger_window_event_counter_unit.sv
// channel   | direction | handshake            | payload
// s_        | in        | s_tvalid / s_tready  | s_tdata: time_value; s_tuser: kind
// m_        | out       | m_tvalid / m_tready  | m_tdata: event_count; m_tuser: status
// cfg_      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a load, restart or ignored kind is handled in the idle state; a trigger
// walks the store from the search pointer, one store read per cycle, in a head scan
// and then a tail scan; a halted trigger goes straight to the result
// reset clears counters, pointer and halt flag; the store is not cleared
// the result register lets the next transaction in while a result waits on m_tready
module trigger_window_event_counter_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [twec_pkg::S_TDATA_W-1:0]      s_tdata,   // time_value
    input  logic [twec_pkg::KIND_W-1:0]         s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [twec_pkg::M_TDATA_W-1:0]      m_tdata,   // event_count, zero pad
    output logic [twec_pkg::STATUS_W-1:0]       m_tuser,   // status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twec_pkg::TIME_W-1:0]         cfg_data
);

    twec_pkg::window_cfg_t   cfg_reg,     cfg_next;
    logic                    out_vld_reg, out_vld_next;
    twec_pkg::result_t       out_reg,     out_next;
    logic                    res_valid;
    logic                    res_ready;
    twec_pkg::result_t       res;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_vld_reg || m_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {{(twec_pkg::M_TDATA_W - twec_pkg::COUNT_W){1'b0}}, out_reg.event_count};
    assign m_tuser   = out_reg.status;

    twec_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_time   (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (twec_pkg::cfg_reg_t'(cfg_index))
                twec_pkg::CFG_HEAD_OFFSET: cfg_next.head_offset = cfg_data;
                twec_pkg::CFG_TAIL_OFFSET: cfg_next.tail_offset = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        priority if (res_valid && res_ready)
        begin
            out_vld_next = 1'b1;
            out_next     = res;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
